[rtl/cptqf_pkg.sv]
// cidr prefix-tree query filter: shared types and codes
// used by the channel interfaces and the top level; no dependencies

package cptqf_pkg;

	// node kinds as carried in node_kind
	typedef enum logic [1:0] {
		KIND_LEAF  = 2'd0,
		KIND_QUAD  = 2'd1,
		KIND_SPLIT = 2'd2,
		KIND_SAME  = 2'd3
	} kind_t;

	// key operators as carried in strategy; codes above STRAT_NOKEY mean no key too
	typedef enum logic [3:0] {
		STRAT_LT    = 4'd0,
		STRAT_LE    = 4'd1,
		STRAT_EQ    = 4'd2,
		STRAT_GE    = 4'd3,
		STRAT_GT    = 4'd4,
		STRAT_NE    = 4'd5,
		STRAT_SUB   = 4'd6,
		STRAT_SUBEQ = 4'd7,
		STRAT_SUP   = 4'd8,
		STRAT_SUPEQ = 4'd9,
		STRAT_OTHER = 4'd10,
		STRAT_NOKEY = 4'd11
	} strat_t;

	localparam logic [3:0] MASK_ALL  = 4'b1111;
	localparam logic [3:0] MASK_HIGH = 4'b1100;
	localparam logic [3:0] MASK_LOW  = 4'b0011;
	localparam logic [3:0] MASK_LEAF = 4'b0001;

	localparam logic [7:0] LEN_MAX_V4 = 8'd32;
	localparam logic [7:0] LEN_MAX_V6 = 8'd128;

	typedef struct packed {
		logic [1:0]  node_kind;
		logic        first_key;
		logic        last_key;
		logic [3:0]  strategy;
		logic        prefix_is_v6;
		logic [7:0]  prefix_len;
		logic [63:0] prefix_addr_hi;
		logic [63:0] prefix_addr_lo;
		logic        key_is_v6;
		logic [7:0]  key_len;
		logic [63:0] key_addr_hi;
		logic [63:0] key_addr_lo;
	} query_t;

	typedef struct packed {
		logic [3:0] visit_mask;
	} result_t;

endpackage

[rtl/cptqf_query_if.sv]
// query channel: valid/ready handshake carrying one query word
// depends on cptqf_pkg

interface cptqf_query_if;
	logic                valid;
	logic                ready;
	cptqf_pkg::query_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/cptqf_result_if.sv]
// result channel: valid/ready handshake carrying one visit mask word
// depends on cptqf_pkg

interface cptqf_result_if;
	logic                valid;
	logic                ready;
	cptqf_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/cidr_prefix_tree_query_filter.sv]
// top level of the cidr prefix-tree query filter
// depends on cptqf_pkg, cptqf_query_if and cptqf_result_if

// Takes one query word per clock and, for the tree node described in it, narrows a
// 4-bit running mask of children to visit (bit 0 is the match flag at a leaf, bits 0
// and 1 are IPv4 and IPv6 at a family-split node). A word with first_key loads the
// node's start value before its key is applied; a word with last_key delivers the
// mask on the result channel after its key is applied; other words produce nothing.
// Throughput is one word per cycle; while a result waits to be taken, words without
// last_key keep flowing at that rate. The word is registered in the input register,
// then the clamped-length 128-bit masked compares and the mask logic feed the result
// register and the running mask. That compare is what sets the clock rate. A word
// without last_key never stalls; a word with last_key waits only if an earlier result
// is still held. Reset clears the running mask.
module cidr_prefix_tree_query_filter (
	input  logic                   clk,
	input  logic                   arst_n,
	cptqf_query_if.sink            query,
	cptqf_result_if.source         verdict
);

	// input register
	logic                 valid_s1;
	cptqf_pkg::query_t    word_s1;

	// result register and running mask
	logic                 valid_s2;
	logic [3:0]           visit_s2;
	logic [3:0]           mask_q;

	logic                 advance;
	logic [3:0]           mask_next;

	// clamped lengths and compare results
	logic [7:0]           cb;
	logic [7:0]           kb;
	logic [7:0]           nmin;
	logic [127:0]         paddr;
	logic [127:0]         kaddr;
	logic [127:0]         cmp_mask;
	logic [127:0]         full_mask;
	logic [127:0]         pm;
	logic [127:0]         km;
	logic [127:0]         pf;
	logic [127:0]         kf;
	logic                 ord_lt;
	logic                 ord_gt;
	logic                 full_lt;
	logic                 full_gt;
	logic                 nbit;
	logic [3:0]           mask_start;
	logic [3:0]           mask_base;

	function automatic logic [7:0] clamp_len(input logic v6, input logic [7:0] len);
		logic [7:0] mx;
		mx = v6 ? cptqf_pkg::LEN_MAX_V6 : cptqf_pkg::LEN_MAX_V4;
		return (len > mx) ? mx : len;
	endfunction

	// family-split node: only the key's family decides
	function automatic logic [3:0] split_key(input logic [3:0] m, input logic [3:0] st,
			input logic kv6);
		logic lo_op;
		logic hi_op;
		logic [3:0] r;
		lo_op = (st == cptqf_pkg::STRAT_LT) || (st == cptqf_pkg::STRAT_LE);
		hi_op = (st == cptqf_pkg::STRAT_GE) || (st == cptqf_pkg::STRAT_GT);
		r = m;
		if (lo_op) begin
			if (!kv6) r = m & 4'b0001;
		end else if (hi_op) begin
			if (kv6) r = m & 4'b0010;
		end else if (st != cptqf_pkg::STRAT_NE) begin
			r = m & (kv6 ? 4'b0010 : 4'b0001);
		end
		return r;
	endfunction

	// four-way node or leaf: narrow the mask from the precomputed compares
	function automatic logic [3:0] apply_key(
			input logic [3:0] m_in, input logic leaf, input logic [3:0] st,
			input logic pv6, input logic kv6, input logic [7:0] c, input logic [7:0] k,
			input logic olt, input logic ogt, input logic nb,
			input logic flt, input logic fgt);
		logic lo_op;
		logic hi_op;
		logic [3:0] m;
		logic [7:0] fmax;
		lo_op = (st == cptqf_pkg::STRAT_LT) || (st == cptqf_pkg::STRAT_LE);
		hi_op = (st == cptqf_pkg::STRAT_GE) || (st == cptqf_pkg::STRAT_GT);
		m = m_in;
		fmax = kv6 ? cptqf_pkg::LEN_MAX_V6 : cptqf_pkg::LEN_MAX_V4;

		// families differ: IPv4 orders before IPv6
		if (pv6 != kv6) begin
			if (lo_op) begin
				if (!kv6 && pv6) m = 4'b0000;
			end else if (hi_op) begin
				if (kv6 && !pv6) m = 4'b0000;
			end else if (st != cptqf_pkg::STRAT_NE) begin
				m = 4'b0000;
			end
			return m;
		end

		// length constraints of the containment and equality operators
		unique case (st)
			cptqf_pkg::STRAT_SUB: begin
				if (c <= k) m = m & cptqf_pkg::MASK_HIGH;
			end
			cptqf_pkg::STRAT_SUBEQ: begin
				if (c < k) m = m & cptqf_pkg::MASK_HIGH;
			end
			cptqf_pkg::STRAT_SUP: begin
				if ({1'b0, c} + 9'd1 == {1'b0, k}) m = m & cptqf_pkg::MASK_LOW;
				else if (c >= k) m = 4'b0000;
			end
			cptqf_pkg::STRAT_SUPEQ: begin
				if (c == k) m = m & cptqf_pkg::MASK_LOW;
				else if (c > k) m = 4'b0000;
			end
			cptqf_pkg::STRAT_EQ: begin
				if (c < k) m = m & cptqf_pkg::MASK_HIGH;
				else if (c == k) m = m & cptqf_pkg::MASK_LOW;
				else m = 4'b0000;
			end
			default: begin
			end
		endcase
		if (m == 4'b0000) return 4'b0000;

		// common bits differ
		if (olt || ogt) begin
			if (lo_op) begin
				if (ogt) m = 4'b0000;
			end else if (hi_op) begin
				if (olt) m = 4'b0000;
			end else if (st != cptqf_pkg::STRAT_NE) begin
				m = 4'b0000;
			end
			return m;
		end

		// longer key: its next bit picks between the two longer children
		if (((m & cptqf_pkg::MASK_HIGH) != 4'b0000) && (c < k)) begin
			if (lo_op) begin
				if (!nb) m = m & 4'b0111;
			end else if (hi_op) begin
				if (nb) m = m & 4'b1011;
			end else if (st != cptqf_pkg::STRAT_NE) begin
				m = m & (nb ? 4'b1011 : 4'b0111);
			end
			if (m == 4'b0000) return 4'b0000;
		end

		if (st > cptqf_pkg::STRAT_NE) return m;

		if (lo_op) begin
			if (c == k) m = m & cptqf_pkg::MASK_LOW;
			else if (c > k) m = 4'b0000;
		end else if (hi_op) begin
			if (c < k) m = m & cptqf_pkg::MASK_HIGH;
		end
		if (m == 4'b0000) return 4'b0000;
		if (c != k) return m;

		// equal lengths: the key's next bit picks between the two shorter children
		if (!leaf && ((m & cptqf_pkg::MASK_LOW) != 4'b0000) && (c < fmax)) begin
			if (lo_op) begin
				if (!nb) m = m & 4'b1101;
			end else if (hi_op) begin
				if (nb) m = m & 4'b1110;
			end else if (st != cptqf_pkg::STRAT_NE) begin
				m = m & (nb ? 4'b1110 : 4'b1101);
			end
			if (m == 4'b0000) return 4'b0000;
		end

		// leaf: full-width compare of the stored value against the key
		if (leaf) begin
			unique case (st)
				cptqf_pkg::STRAT_LT: if (!flt) m = 4'b0000;
				cptqf_pkg::STRAT_LE: if (fgt) m = 4'b0000;
				cptqf_pkg::STRAT_EQ: if (flt || fgt) m = 4'b0000;
				cptqf_pkg::STRAT_GE: if (flt) m = 4'b0000;
				cptqf_pkg::STRAT_GT: if (!fgt) m = 4'b0000;
				default: if (!flt && !fgt) m = 4'b0000;
			endcase
		end
		return m;
	endfunction

	// handshake: a word without last_key always moves on, one with it needs a free
	// result register (or one being emptied this cycle)
	assign advance = valid_s1 &&
		(!word_s1.last_key || !valid_s2 || verdict.ready);
	assign query.ready = !valid_s1 || advance;

	// lengths clamped to the family's maximum
	assign cb   = clamp_len(word_s1.prefix_is_v6, word_s1.prefix_len);
	assign kb   = clamp_len(word_s1.key_is_v6, word_s1.key_len);
	assign nmin = (cb < kb) ? cb : kb;

	assign paddr = {word_s1.prefix_addr_hi, word_s1.prefix_addr_lo};
	assign kaddr = {word_s1.key_addr_hi, word_s1.key_addr_lo};

	// left-aligned masks: common prefix, and the prefix family's full width
	assign cmp_mask  = ~({128{1'b1}} >> nmin);
	assign full_mask = word_s1.prefix_is_v6 ? {128{1'b1}} : {{32{1'b1}}, {96{1'b0}}};

	assign pm = paddr & cmp_mask;
	assign km = kaddr & cmp_mask;
	assign pf = paddr & full_mask;
	assign kf = kaddr & full_mask;

	assign ord_lt  = pm < km;
	assign ord_gt  = pm > km;
	assign full_lt = pf < kf;
	assign full_gt = pf > kf;

	// key bit just past the node prefix, counted from the left
	assign nbit = (cb < cptqf_pkg::LEN_MAX_V6) ? kaddr[7'(8'd127 - cb)] : 1'b0;

	// start value by node kind
	always_comb begin
		unique case (cptqf_pkg::kind_t'(word_s1.node_kind))
			cptqf_pkg::KIND_LEAF:  mask_start = cptqf_pkg::MASK_LEAF;
			cptqf_pkg::KIND_SPLIT: mask_start = cptqf_pkg::MASK_LOW;
			default:               mask_start = cptqf_pkg::MASK_ALL;
		endcase
	end

	assign mask_base = word_s1.first_key ? mask_start : mask_q;

	always_comb begin
		mask_next = mask_base;
		if (word_s1.node_kind == cptqf_pkg::KIND_SAME) begin
			mask_next = cptqf_pkg::MASK_ALL;
		end else if (word_s1.strategy <= cptqf_pkg::STRAT_OTHER) begin
			if (word_s1.node_kind == cptqf_pkg::KIND_SPLIT) begin
				mask_next = split_key(mask_base, word_s1.strategy, word_s1.key_is_v6);
			end else begin
				mask_next = apply_key(mask_base,
					word_s1.node_kind == cptqf_pkg::KIND_LEAF, word_s1.strategy,
					word_s1.prefix_is_v6, word_s1.key_is_v6, cb, kb,
					ord_lt, ord_gt, nbit, full_lt, full_gt);
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (query.ready) begin
			valid_s1 <= query.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (query.valid && query.ready) begin
			word_s1 <= query.data;
		end
	end

	// running mask and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= 4'b0000;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) mask_q <= mask_next;
			if (advance && word_s1.last_key) valid_s2 <= 1'b1;
			else if (verdict.ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.last_key) begin
			visit_s2 <= mask_next;
		end
	end

	assign verdict.valid           = valid_s2;
	assign verdict.data.visit_mask = visit_s2;

	// a last key always lands in the result register
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && word_s1.last_key |=> valid_s2)
		else $error("last key did not produce a result");

	// an all-same node leaves every child set
	a_same_sets_all: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (word_s1.node_kind == cptqf_pkg::KIND_SAME)
		|=> mask_q == cptqf_pkg::MASK_ALL)
		else $error("all-same node did not set the full mask");

	// without a start and outside an all-same node, keys only ever clear bits of the running mask
	a_keys_only_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !word_s1.first_key && (word_s1.node_kind != cptqf_pkg::KIND_SAME)
		|=> (mask_q & ~$past(mask_q)) == 4'b0000)
		else $error("running mask gained a bit without a start");

endmodule
